FILE: rtl/core/crcs_pkg.sv
// Shared types and constants of the Catmull-Rom curve sampler.
// Used by crcs_ctrl, crcs_dp and catmull_rom_curve_sampler_unit; no dependencies.
`default_nettype none

package crcs_pkg;

	localparam int NUM_POINTS_DEF  = 10;
	localparam int SEG_SAMPLES_DEF = 12;

	localparam int H_W    = 8;   // control-point height
	localparam int X_W    = 9;   // sample x coordinate
	localparam int Y_W    = 8;   // sample height
	localparam int FT_W   = 4;   // Q4 curve parameter
	localparam int COEF_W = 16;  // cubic coefficients
	localparam int PROD_W = 24;  // Horner products

	localparam logic [H_W-1:0] X_ORIGIN_RST = 8'd10;
	localparam logic [Y_W-1:0] Y_MAX        = 8'd255;

	// controller to datapath commands
	typedef struct packed {
		logic accept;     // capture the request height
		logic shift;      // advance the point window
		logic load;       // load segment coefficients
		logic sel_b;      // closing segment of the curve
		logic first;      // opening segment of the curve
		logic issue;      // start one curve sample
		logic issue_end;  // start the closing end point
	} crcs_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/crcs_ctrl.sv
// Sequencer of the curve sampler: counts points, steps through segments and samples.
// Depends on crcs_pkg; drives crcs_dp by a crcs_cmd_t command word.
`default_nettype none

module crcs_ctrl #(
	parameter int NUM_POINTS  = crcs_pkg::NUM_POINTS_DEF,
	parameter int SEG_SAMPLES = crcs_pkg::SEG_SAMPLES_DEF,
	localparam int TW = $clog2(SEG_SAMPLES)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               adv,
	output crcs_pkg::crcs_cmd_t     cmd,
	output logic [TW-1:0]           t_idx
);
	import crcs_pkg::*;

	localparam int PS_W = $clog2(NUM_POINTS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT,
		S_LOAD_A,
		S_RUN_A,
		S_LOAD_B,
		S_RUN_B,
		S_RUN_END
	} state_t;

	state_t          state_q;
	logic [PS_W-1:0] pts_q;
	logic [TW-1:0]   t_q;
	logic            first_q;
	logic            last_q;
	logic            accept;
	logic            t_last;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign t_last   = (t_q == TW'(SEG_SAMPLES - 1));
	assign t_idx    = t_q;

	always_comb begin
		cmd           = '0;
		cmd.accept    = accept;
		cmd.first     = first_q;
		case (state_q)
			S_SHIFT:   cmd.shift = 1'b1;
			S_LOAD_A:  cmd.load  = 1'b1;
			S_RUN_A:   cmd.issue = 1'b1;
			S_LOAD_B: begin
				cmd.load  = 1'b1;
				cmd.sel_b = 1'b1;
			end
			S_RUN_B:   cmd.issue = 1'b1;
			S_RUN_END: cmd.issue_end = 1'b1;
			default:   cmd.shift = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pts_q   <= '0;
			t_q     <= '0;
			first_q <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						first_q <= (pts_q == PS_W'(2));
						last_q  <= (pts_q == PS_W'(NUM_POINTS - 1));
						pts_q   <= (pts_q == PS_W'(NUM_POINTS - 1)) ? '0 : pts_q + 1'b1;
						state_q <= (pts_q >= PS_W'(2)) ? S_LOAD_A : S_SHIFT;
					end
				end
				S_SHIFT:  state_q <= S_IDLE;
				S_LOAD_A: begin
					t_q     <= '0;
					state_q <= S_RUN_A;
				end
				S_RUN_A: begin
					if (adv) begin
						t_q <= t_last ? '0 : t_q + 1'b1;
						if (t_last) state_q <= last_q ? S_LOAD_B : S_SHIFT;
					end
				end
				S_LOAD_B: begin
					t_q     <= '0;
					state_q <= S_RUN_B;
				end
				S_RUN_B: begin
					if (adv) begin
						t_q <= t_last ? '0 : t_q + 1'b1;
						if (t_last) state_q <= S_RUN_END;
					end
				end
				S_RUN_END: begin
					if (adv) state_q <= S_SHIFT;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		pts_q <= PS_W'(NUM_POINTS - 1))
		else $error("point count beyond curve length");

	a_curve_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && pts_q == PS_W'(NUM_POINTS - 1) |=> pts_q == '0)
		else $error("point count did not restart after last point");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN_A || state_q == S_RUN_B) && !adv |=> $stable(t_q))
		else $error("sample index moved while stalled");

	a_end_then_shift: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RUN_END && adv |=> state_q == S_SHIFT)
		else $error("end point not followed by window shift");

endmodule

`default_nettype wire

FILE: rtl/core/crcs_dp.sv
// Datapath of the curve sampler: point window, coefficients, Horner pipeline, result register.
// Depends on crcs_pkg; steered by crcs_ctrl through a crcs_cmd_t command word.
`default_nettype none

module crcs_dp #(
	parameter int SEG_SAMPLES = crcs_pkg::SEG_SAMPLES_DEF,
	localparam int TW = $clog2(SEG_SAMPLES)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire crcs_pkg::crcs_cmd_t       cmd,
	input  wire logic [TW-1:0]             t_idx,
	input  wire logic [crcs_pkg::H_W-1:0]  point_height,
	input  wire logic                      cfg_valid,
	input  wire logic [crcs_pkg::H_W-1:0]  cfg_data,
	output logic                           adv,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [crcs_pkg::X_W-1:0]       sample_x,
	output logic [crcs_pkg::Y_W-1:0]       sample_y,
	output logic                           curve_done
);
	import crcs_pkg::*;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	function automatic coef_t ext_pt(input logic [H_W-1:0] p);
		return COEF_W'(signed'({1'b0, p}));
	endfunction

	function automatic prod_t ext_ft(input logic [FT_W-1:0] f);
		return PROD_W'(signed'({1'b0, f}));
	endfunction

	logic [FT_W-1:0] ft_tab [SEG_SAMPLES];

	for (genvar g = 0; g < SEG_SAMPLES; g++) begin : g_ft
		assign ft_tab[g] = FT_W'((g * 16) / SEG_SAMPLES);
	end

	logic [H_W-1:0] x_origin_q;
	logic [H_W-1:0] w_q [3];
	logic [H_W-1:0] cur_q;
	logic [X_W-1:0] xoff_q;
	coef_t          a_q, b_q, c_q, d_q;

	logic [H_W-1:0] p0, p1, p2, p3;
	coef_t          s0, s1, s2, s3, dlt;

	// pipeline
	logic             v_s1, v_s2, v_s3;
	prod_t            m1_s1, m2_s2, m3_s3;
	coef_t            b_s1, c_s1, c_s2, d_s1, d_s2, d_s3;
	logic [FT_W-1:0]  ft_s1, ft_s2;
	logic [X_W-1:0]   xoff_s1, xoff_s2, xoff_s3;
	logic             end_s1, end_s2, end_s3;
	logic [H_W-1:0]   yend_s1, yend_s2, yend_s3;

	logic             out_valid_q;
	logic [X_W-1:0]   sample_x_q;
	logic [Y_W-1:0]   sample_y_q;
	logic             done_q;

	prod_t            y_full;
	logic [Y_W-1:0]   y_clamp;

	assign adv = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_origin_q <= X_ORIGIN_RST;
		end else if (cfg_valid) begin
			x_origin_q <= cfg_data;
		end
	end

	// segment control points, end points repeated at the curve ends
	assign p0 = (cmd.sel_b || cmd.first) ? w_q[1] : w_q[0];
	assign p1 = cmd.sel_b ? w_q[2] : w_q[1];
	assign p2 = cmd.sel_b ? cur_q : w_q[2];
	assign p3 = cur_q;

	assign s0  = ext_pt(p0);
	assign s1  = ext_pt(p1);
	assign s2  = ext_pt(p2);
	assign s3  = ext_pt(p3);
	assign dlt = s1 - s2;

	always_ff @(posedge clk) begin
		if (cmd.accept) cur_q <= point_height;
		if (cmd.shift) begin
			w_q[0] <= w_q[1];
			w_q[1] <= w_q[2];
			w_q[2] <= cur_q;
		end
		if (cmd.load) begin
			a_q <= (s3 - s0 + (dlt <<< 1) + dlt) <<< 3;
			b_q <= ((s0 <<< 1) - (s1 <<< 2) - s1 + (s2 <<< 2) - s3) <<< 3;
			c_q <= (s2 - s0) <<< 3;
			d_q <= s1 <<< 4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xoff_q <= '0;
		end else if (adv) begin
			if (cmd.issue_end) xoff_q <= '0;
			else if (cmd.issue) xoff_q <= xoff_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= cmd.issue || cmd.issue_end;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	assign y_full  = (((m3_s3 >>> 4) + PROD_W'(d_s3)) >>> 4);
	assign y_clamp = (y_full < 0) ? '0 :
	                 (y_full > prod_t'(Y_MAX)) ? Y_MAX : y_full[Y_W-1:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			m1_s1   <= PROD_W'(a_q) * ext_ft(ft_tab[t_idx]);
			b_s1    <= b_q;
			c_s1    <= c_q;
			d_s1    <= d_q;
			ft_s1   <= ft_tab[t_idx];
			xoff_s1 <= xoff_q;
			end_s1  <= cmd.issue_end;
			yend_s1 <= cur_q;

			m2_s2   <= ((m1_s1 >>> 4) + PROD_W'(b_s1)) * ext_ft(ft_s1);
			c_s2    <= c_s1;
			d_s2    <= d_s1;
			ft_s2   <= ft_s1;
			xoff_s2 <= xoff_s1;
			end_s2  <= end_s1;
			yend_s2 <= yend_s1;

			m3_s3   <= ((m2_s2 >>> 4) + PROD_W'(c_s2)) * ext_ft(ft_s2);
			d_s3    <= d_s2;
			xoff_s3 <= xoff_s2;
			end_s3  <= end_s2;
			yend_s3 <= yend_s2;

			sample_x_q <= X_W'(x_origin_q) + xoff_s3;
			sample_y_q <= end_s3 ? yend_s3 : y_clamp;
			done_q     <= end_s3;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_x   = sample_x_q;
	assign sample_y   = sample_y_q;
	assign curve_done = done_q;

	a_pipe_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s1) && $stable(v_s2) && $stable(v_s3))
		else $error("pipeline moved while result held");

	a_xoff_restart: assert property (@(posedge clk) disable iff (!arst_n)
		adv && cmd.issue_end |=> xoff_q == '0)
		else $error("x offset not cleared after end point");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(sample_x_q) &&
		$stable(sample_y_q) && $stable(done_q))
		else $error("waiting result changed before acceptance");

endmodule

`default_nettype wire

FILE: rtl/core/catmull_rom_curve_sampler_unit.sv
// Top level of the Catmull-Rom curve sampler: joins crcs_ctrl and crcs_dp.
// Depends on crcs_pkg, crcs_ctrl and crcs_dp.
//
//   channel   direction  handshake               payload
//   in        to block   in_valid / in_ready     point_height
//   out       from block out_valid / out_ready   sample_x, sample_y, curve_done
//   cfg       to block   cfg_valid / cfg_ready   cfg_data (x_origin)
//
// One request is taken only while the sequencer is idle. The first two points of a
// curve only fill the point window; each later point issues SEG_SAMPLES samples, the last
// point another SEG_SAMPLES and the end point. Samples are issued one per cycle, unless a held
// result stalls the issue, into the Horner stages s1, s2, s3 and then the result register.
// A result held by low out_ready freezes the pipeline and the issue.
// Reset restores x_origin to 10 and starts a new curve; cfg_ready is always high.
`default_nettype none

module catmull_rom_curve_sampler_unit #(
	parameter int NUM_POINTS  = crcs_pkg::NUM_POINTS_DEF,
	parameter int SEG_SAMPLES = crcs_pkg::SEG_SAMPLES_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [crcs_pkg::H_W-1:0]  point_height,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [crcs_pkg::X_W-1:0]       sample_x,
	output logic [crcs_pkg::Y_W-1:0]       sample_y,
	output logic                           curve_done,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [crcs_pkg::H_W-1:0]  cfg_data
);
	import crcs_pkg::*;

	localparam int TW = $clog2(SEG_SAMPLES);

	crcs_cmd_t     cmd;
	logic [TW-1:0] t_idx;
	logic          adv;

	assign cfg_ready = 1'b1;

	crcs_ctrl #(
		.NUM_POINTS (NUM_POINTS),
		.SEG_SAMPLES(SEG_SAMPLES)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.adv     (adv),
		.cmd     (cmd),
		.t_idx   (t_idx)
	);

	crcs_dp #(
		.SEG_SAMPLES(SEG_SAMPLES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.t_idx       (t_idx),
		.point_height(point_height),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.adv         (adv),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sample_x    (sample_x),
		.sample_y    (sample_y),
		.curve_done  (curve_done)
	);

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking bench for catmull_rom_curve_sampler_unit: point heights in, curve samples out.
// Keeps its own curve predictor and checks every sample; depends on crcs_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;

	localparam int NP          = crcs_pkg::NUM_POINTS_DEF;
	localparam int SS          = crcs_pkg::SEG_SAMPLES_DEF;
	localparam int H_W         = crcs_pkg::H_W;
	localparam int X_W         = crcs_pkg::X_W;
	localparam int Y_W         = crcs_pkg::Y_W;
	localparam int SETTLE      = 2 * SS + 16;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_AT     = 100;
	localparam int HOLD_LEN    = 400;

	typedef struct packed {
		logic [X_W-1:0] x;
		logic [Y_W-1:0] y;
		logic           done;
	} sample_t;

	logic           clk          = 1'b0;
	logic           arst_n       = 1'b0;
	logic           in_valid     = 1'b0;
	logic [H_W-1:0] point_height = '0;
	logic           out_ready    = 1'b0;
	logic           cfg_valid    = 1'b0;
	logic [H_W-1:0] cfg_data     = '0;
	logic           in_ready;
	logic           out_valid;
	logic [X_W-1:0] sample_x;
	logic [Y_W-1:0] sample_y;
	logic           curve_done;
	logic           cfg_ready;

	logic [H_W-1:0] pending_heights[$];
	sample_t        exp_samples[$];
	int             items_queued  = 0;
	int             items_taken   = 0;
	int             send_idle_pct = 0;
	int             recv_idle_pct = 0;
	int             mismatches    = 0;
	int             stall_cycles  = 0;
	int             hold_cnt      = 0;
	logic           hold_done     = 1'b0;

	// predictor state
	logic [H_W-1:0] x_org = crcs_pkg::X_ORIGIN_RST;
	logic [H_W-1:0] win[3];
	int             seen  = 0;

	catmull_rom_curve_sampler_unit #(
		.NUM_POINTS (NP),
		.SEG_SAMPLES(SS)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.point_height(point_height),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sample_x    (sample_x),
		.sample_y    (sample_y),
		.curve_done  (curve_done),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [Y_W-1:0] curve_height(int p0, int p1, int p2, int p3, int ft);
		int a, b, c, d, y;
		a = 8 * (-p0 + 3 * p1 - 3 * p2 + p3);
		b = 8 * (2 * p0 - 5 * p1 + 4 * p2 - p3);
		c = 8 * (p2 - p0);
		d = 16 * p1;
		y = (a * ft) >>> 4;
		y = ((y + b) * ft) >>> 4;
		y = ((y + c) * ft) >>> 4;
		y = (y + d) >>> 4;
		if (y < 0)
			y = 0;
		if (y > 255)
			y = 255;
		return y[Y_W-1:0];
	endfunction

	task automatic push_segment(int seg, int p0, int p1, int p2, int p3);
		sample_t s;
		int      xs;
		for (int t = 0; t < SS; t++) begin
			xs     = int'(x_org) + seg * SS + t;
			s.x    = xs[X_W-1:0];
			s.y    = curve_height(p0, p1, p2, p3, (t * 16) / SS);
			s.done = 1'b0;
			exp_samples.push_back(s);
		end
	endtask

	task automatic predict_point(logic [H_W-1:0] h);
		sample_t s;
		int      xs;
		if (seen >= 2)
			push_segment(seen - 2, (seen == 2) ? win[1] : win[0], win[1], win[2], h);
		if (seen + 1 >= NP) begin
			push_segment(NP - 2, win[1], win[2], h, h);
			xs     = int'(x_org) + (NP - 1) * SS;
			s.x    = xs[X_W-1:0];
			s.y    = h;
			s.done = 1'b1;
			exp_samples.push_back(s);
			seen = 0;
		end else begin
			seen = seen + 1;
		end
		win[0] = win[1];
		win[1] = win[2];
		win[2] = h;
	endtask

	task automatic report_mismatch(string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin : driver
		logic           nxt_valid;
		logic [H_W-1:0] nxt_h;
		nxt_valid = in_valid;
		nxt_h     = point_height;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_point(point_height);
				items_taken++;
				nxt_valid = 1'b0;
			end
			if (!nxt_valid && pending_heights.size() > 0 &&
			    $urandom_range(0, 99) >= send_idle_pct) begin
				nxt_valid = 1'b1;
				nxt_h     = pending_heights.pop_front();
			end
		end
		in_valid     <= nxt_valid;
		point_height <= nxt_h;
	end

	always @(posedge clk) begin : monitor
		logic    nxt_ready;
		sample_t want;
		nxt_ready = 1'b0;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (exp_samples.size() == 0) begin
					report_mismatch($sformatf("sample x=%0d y=%0d done=%0d with nothing pending",
					                          sample_x, sample_y, curve_done));
				end else begin
					want = exp_samples.pop_front();
					if (sample_x !== want.x)
						report_mismatch($sformatf("sample_x %0d, expected %0d", sample_x, want.x));
					if (sample_y !== want.y)
						report_mismatch($sformatf("sample_y %0d, expected %0d (x %0d)",
						                          sample_y, want.y, want.x));
					if (curve_done !== want.done)
						report_mismatch($sformatf("curve_done %0d, expected %0d (x %0d)",
						                          curve_done, want.done, want.x));
				end
			end
			// hold off once for a long stretch so the block backs up
			if (!hold_done && items_taken >= HOLD_AT) begin
				hold_cnt  = HOLD_LEN;
				hold_done = 1'b1;
			end
			if (hold_cnt > 0)
				hold_cnt--;
			else
				nxt_ready = $urandom_range(0, 99) >= recv_idle_pct;
		end
		out_ready <= nxt_ready;
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
		    (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic queue_height(logic [H_W-1:0] h);
		pending_heights.push_back(h);
		items_queued++;
	endtask

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0)
				queue_height($urandom_range(0, 1) ? 8'hFF : 8'h00);
			else
				queue_height(8'($urandom_range(0, 255)));
		end
	endtask

	// wait until every request is taken and every sample is back, then drain
	task automatic settle();
		do
			@(posedge clk);
		while (items_taken != items_queued);
		while (exp_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_origin(logic [H_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		x_org = v;
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		logic [H_W-1:0] curve_a[NP] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0,
		                                 8'd255, 8'd255, 8'd255, 8'd0, 8'd0};
		logic [H_W-1:0] curve_b[NP] = '{8'd255, 8'd0, 8'd0, 8'd255, 8'd255,
		                                 8'd0, 8'd0, 8'd128, 8'd255, 8'd255};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 28;
		recv_idle_pct = 57;
		repeat (2) @(posedge clk);
		// default origin first, then the lowest origin
		foreach (curve_a[i])
			queue_height(curve_a[i]);
		settle();
		write_origin(8'd0);
		foreach (curve_a[i])
			queue_height(curve_a[i]);
		settle();
		write_origin(8'd255);
		for (int i = 0; i < NP / 2; i++)
			queue_height(curve_b[i]);
		settle();
		// change origin part-way through a curve
		write_origin(8'd37);
		for (int i = NP / 2; i < NP; i++)
			queue_height(curve_b[i]);
		settle();

		write_origin(8'($urandom_range(0, 255)));
		queue_random(127);
		settle();

		send_idle_pct = 57;
		recv_idle_pct = 28;
		write_origin(8'd255);
		queue_random(131);
		settle();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_origin(8'($urandom_range(0, 255)));
		queue_random(132);
		settle();

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
